// ===== rtl/assert_macros.svh =====
// Assertion macros for the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising edge, skipped while reset is high
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, skipped while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/prta_pkg.sv =====
// Package for the port rate threshold alarm unit: constants, codes and types
package prta_pkg;
   localparam int NumPortsDefault = 64;
   localparam int PortW = 6;
   localparam logic [31:0] DefLinkBps = 32'd131072000;
   localparam logic [6:0] PctScale = 7'd100;

   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_OVER  = 2'd1;
   localparam logic [1:0] EV_CLEAR = 2'd2;

   localparam logic [2:0] CSR_DROP_EN  = 3'd0;
   localparam logic [2:0] CSR_DROP_THR = 3'd1;
   localparam logic [2:0] CSR_DROP_RES = 3'd2;
   localparam logic [2:0] CSR_BAND_EN  = 3'd3;
   localparam logic [2:0] CSR_BAND_THR = 3'd4;
   localparam logic [2:0] CSR_BAND_RES = 3'd5;
   localparam logic [2:0] CSR_LINK_BPS = 3'd6;

   // divider handshake bundles
   typedef struct packed {
      logic        start;
      logic [127:0] num;
      logic [63:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic        sat;   // quotient exceeds 32 bits
      logic [63:0] quo;   // low 64 bits of quotient
   } div_rsp_type;

   // alarm decision: event, value, next over bit and next last-sent time
   typedef struct packed {
      logic [1:0]  ev;
      logic [31:0] val;
      logic        over;
      logic [31:0] last;
   } alarm_type;

   function automatic alarm_type eval_alarm(input logic [31:0] value,
                                            input logic [7:0] thr,
                                            input logic [31:0] resend,
                                            input logic [31:0] now,
                                            input logic over,
                                            input logic [31:0] last);
      alarm_type r;
      logic send;
      r.ev = EV_NONE;
      r.val = '0;
      r.over = over;
      r.last = last;
      send = 1'b0;
      if (thr != 8'd0) begin
         if (value > {24'd0, thr}) begin
            if (resend == 32'd0) send = !over;
            else send = (now - last) > resend;
            if (send) begin
               r.ev = EV_OVER;
               r.val = value;
               r.last = now;
            end
            r.over = 1'b1;
         end else begin
            if (over) begin
               r.ev = EV_CLEAR;
               r.val = value;
            end
            r.over = 1'b0;
            r.last = '0;
         end
      end else begin
         if (over) r.ev = EV_CLEAR;
         r.over = 1'b0;
         r.last = '0;
      end
      return r;
   endfunction
endpackage

// ===== rtl/prta_div.sv =====
// Shared restoring divider, 128-bit dividend by 64-bit divisor, one bit per cycle
module prta_div
   import prta_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   logic [127:0] num_ff, num_in;
   logic [63:0]  den_ff, den_in;
   logic [63:0]  rem_ff, rem_in;
   logic [63:0]  quo_ff, quo_in;
   logic         sat_ff, sat_in;
   logic [7:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [64:0]  shifted;
   logic         qb;

   always_comb begin
      shifted = {rem_ff, num_ff[127]};
      qb = shifted >= {1'b0, den_ff};
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      sat_in = sat_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         num_in = req.num;
         den_in = req.den;
         rem_in = '0;
         quo_in = '0;
         sat_in = 1'b0;
         cnt_in = 8'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[126:0], 1'b0};
         rem_in = qb ? 64'(shifted - {1'b0, den_ff}) : shifted[63:0];
         quo_in = {quo_ff[62:0], qb};
         if (quo_ff[31:0] != '0 && quo_ff[31]) sat_in = 1'b1;
         else if (quo_ff[63:32] != '0) sat_in = 1'b1;
         cnt_in = cnt_ff + 8'd1;
         if (cnt_ff == 8'd127) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.sat = sat_ff || (quo_ff[63:32] != '0);
   assign rsp.quo = quo_ff;
endmodule

// ===== rtl/port_rate_threshold_alarm_unit.sv =====
// Top level of the port rate threshold alarm unit
// One request is one counter sample for one port. busy is high from the
// accepting edge until the result strobe. A request steps through a table
// read, up to four divisions and a finish step. The single bit-serial 128/64
// divider does the divisions. It computes, one after the other, rx rate, tx
// rate, drop percent and rx utilisation percent. A skipped division passes
// through without starting the divider.
// The result is shown for exactly one cycle with rsp_valid; the receiver
// cannot stall it. Port state lives in arrays indexed by port; the counter
// history is undefined until the first sample of that port writes it.
module port_rate_threshold_alarm_unit
   import prta_pkg::*;
#(
   parameter int NUM_PORTS = NumPortsDefault
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [PortW-1:0]  req_port,
   input  logic [31:0]       req_sample_secs,
   input  logic [63:0]       req_rx_byte_count,
   input  logic [63:0]       req_tx_byte_count,
   input  logic [63:0]       req_rx_packet_count,
   input  logic [63:0]       req_rx_drop_count,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data,
   output logic              rsp_valid,
   output logic [PortW-1:0]  rsp_port_out,
   output logic [63:0]       rsp_rx_rate,
   output logic [63:0]       rsp_tx_rate,
   output logic [1:0]        rsp_drop_event,
   output logic [31:0]       rsp_drop_value,
   output logic [1:0]        rsp_band_event,
   output logic [31:0]       rsp_band_value
);
`include "assert_macros.svh"

   localparam int IdxW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOAD = 3'd1;  // table read issued
   localparam logic [2:0] S_RX   = 3'd2;
   localparam logic [2:0] S_TX   = 3'd3;
   localparam logic [2:0] S_DROP = 3'd4;
   localparam logic [2:0] S_BAND = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   // configuration registers
   logic        drop_en_ff, band_en_ff;
   logic [7:0]  drop_thr_ff, band_thr_ff;
   logic [31:0] drop_res_ff, band_res_ff, link_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_en_ff <= 1'b0;
         band_en_ff <= 1'b0;
         drop_thr_ff <= '0;
         band_thr_ff <= '0;
         drop_res_ff <= '0;
         band_res_ff <= '0;
         link_ff <= DefLinkBps;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DROP_EN:  drop_en_ff <= csr_data[0];
            CSR_DROP_THR: drop_thr_ff <= csr_data[7:0];
            CSR_DROP_RES: drop_res_ff <= csr_data;
            CSR_BAND_EN:  band_en_ff <= csr_data[0];
            CSR_BAND_THR: band_thr_ff <= csr_data[7:0];
            CSR_BAND_RES: band_res_ff <= csr_data;
            CSR_LINK_BPS: link_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // per-port history memory (no reset) and alarm state with valid bits
   logic [63:0] prx_mem [NUM_PORTS];
   logic [63:0] ptx_mem [NUM_PORTS];
   logic [31:0] psec_mem [NUM_PORTS];
   logic [31:0] dlast_mem [NUM_PORTS];
   logic [31:0] blast_mem [NUM_PORTS];
   logic [NUM_PORTS-1:0] valid_ff, dover_ff, bover_ff;

   // latched request
   logic [PortW-1:0] port_ff;
   logic [31:0] now_ff;
   logic [63:0] rxb_ff, txb_ff, pkts_ff, drops_ff;
   logic [2:0]  state_ff, state_in;
   logic        inrange_ff;
   logic [IdxW-1:0] idx;

   // table read data, registered
   logic [63:0] prx_rd, ptx_rd;
   logic [31:0] psec_rd, dlast_rd, blast_rd;
   logic        valid_rd, dover_rd, bover_rd;

   // results being built
   logic [63:0] rxr_ff, txr_ff;
   logic [31:0] dpct_ff, bpct_ff;
   logic        launched_ff;

   div_req_type dreq;
   div_rsp_type drsp;

   prta_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   assign idx = IdxW'(port_ff);
   assign busy = (state_ff != S_IDLE);

   logic rates_ok;
   logic rx_grow, tx_grow;
   logic [31:0] dt;
   logic [31:0] pct_q;
   assign rates_ok = valid_rd && (now_ff > psec_rd);
   assign dt = now_ff - psec_rd;
   assign rx_grow = rxb_ff > prx_rd;
   assign tx_grow = txb_ff > ptx_rd;
   assign pct_q = drsp.sat ? 32'hFFFF_FFFF : drsp.quo[31:0];

   // 100 * x as 128 bits (x * 7-bit constant)
   function automatic logic [127:0] times100(input logic [63:0] x);
      return 128'(x) * 128'(PctScale);
   endfunction

   // sequencer: each divide state issues at most once and waits for done, or moves on when skipped
   always_comb begin
      state_in = state_ff;
      dreq.start = 1'b0;
      dreq.num = '0;
      dreq.den = 64'd1;
      unique case (state_ff)
         S_IDLE: if (start) state_in = S_LOAD;
         S_LOAD: state_in = inrange_ff ? S_RX : S_DONE;
         S_RX: begin
            if (!(rates_ok && rx_grow)) state_in = S_TX;
            else if (!launched_ff) begin
               dreq.start = 1'b1;
               dreq.num = {64'd0, rxb_ff - prx_rd};
               dreq.den = {32'd0, dt};
            end else if (drsp.done) state_in = S_TX;
         end
         S_TX: begin
            if (!(rates_ok && tx_grow)) state_in = S_DROP;
            else if (!launched_ff) begin
               dreq.start = 1'b1;
               dreq.num = {64'd0, txb_ff - ptx_rd};
               dreq.den = {32'd0, dt};
            end else if (drsp.done) state_in = S_DROP;
         end
         S_DROP: begin
            if (!(drop_en_ff && pkts_ff != '0)) state_in = S_BAND;
            else if (!launched_ff) begin
               dreq.start = 1'b1;
               dreq.num = times100(drops_ff);
               dreq.den = pkts_ff;
            end else if (drsp.done) state_in = S_BAND;
         end
         S_BAND: begin
            if (!band_en_ff) state_in = S_DONE;
            else if (!launched_ff) begin
               dreq.start = 1'b1;
               dreq.num = times100(rxr_ff);
               dreq.den = {32'd0, (link_ff == '0) ? 32'd1 : link_ff};
            end else if (drsp.done) state_in = S_DONE;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   alarm_type da, ba;
   always_comb begin
      da = eval_alarm(dpct_ff, drop_thr_ff, drop_res_ff, now_ff,
                      valid_rd ? dover_rd : 1'b0, valid_rd ? dlast_rd : 32'd0);
      ba = eval_alarm(bpct_ff, band_thr_ff, band_res_ff, now_ff,
                      valid_rd ? bover_rd : 1'b0, valid_rd ? blast_rd : 32'd0);
   end

   logic fin;
   assign fin = (state_ff == S_DONE);

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         port_ff <= req_port;
         now_ff <= req_sample_secs;
         rxb_ff <= req_rx_byte_count;
         txb_ff <= req_tx_byte_count;
         pkts_ff <= req_rx_packet_count;
         drops_ff <= req_rx_drop_count;
         inrange_ff <= (32'(req_port) < NUM_PORTS);
         rxr_ff <= '0;
         txr_ff <= '0;
         dpct_ff <= '0;
         bpct_ff <= '0;
      end
      // registered table read, in the cycle after accept
      if (state_ff == S_LOAD) begin
         prx_rd <= prx_mem[idx];
         ptx_rd <= ptx_mem[idx];
         psec_rd <= psec_mem[idx];
         dlast_rd <= dlast_mem[idx];
         blast_rd <= blast_mem[idx];
         valid_rd <= valid_ff[idx];
         dover_rd <= dover_ff[idx];
         bover_rd <= bover_ff[idx];
      end
      if (drsp.done) begin
         unique case (state_ff)
            S_RX:   rxr_ff <= drsp.quo;
            S_TX:   txr_ff <= drsp.quo;
            S_DROP: dpct_ff <= pct_q;
            S_BAND: bpct_ff <= pct_q;
            default: ;
         endcase
      end
      if (fin && inrange_ff) begin
         prx_mem[idx] <= rxb_ff;
         ptx_mem[idx] <= txb_ff;
         psec_mem[idx] <= now_ff;
         if (drop_en_ff) dlast_mem[idx] <= da.last;
         else if (!valid_rd) dlast_mem[idx] <= '0;
         if (band_en_ff) blast_mem[idx] <= ba.last;
         else if (!valid_rd) blast_mem[idx] <= '0;
      end
      rsp_port_out <= port_ff;
      rsp_rx_rate <= rxr_ff;
      rsp_tx_rate <= txr_ff;
      rsp_drop_event <= (inrange_ff && drop_en_ff) ? da.ev : EV_NONE;
      rsp_drop_value <= (inrange_ff && drop_en_ff) ? da.val : 32'd0;
      rsp_band_event <= (inrange_ff && band_en_ff) ? ba.ev : EV_NONE;
      rsp_band_value <= (inrange_ff && band_en_ff) ? ba.val : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         launched_ff <= 1'b0;
         rsp_valid <= 1'b0;
         valid_ff <= '0;
         dover_ff <= '0;
         bover_ff <= '0;
      end else begin
         state_ff <= state_in;
         // launch flag drops on every state change
         if (state_in != state_ff) launched_ff <= 1'b0;
         else if (dreq.start) launched_ff <= 1'b1;
         rsp_valid <= fin;
         if (fin && inrange_ff) begin
            valid_ff[idx] <= 1'b1;
            if (drop_en_ff) dover_ff[idx] <= da.over;
            else if (!valid_rd) dover_ff[idx] <= 1'b0;
            if (band_en_ff) bover_ff[idx] <= ba.over;
            else if (!valid_rd) bover_ff[idx] <= 1'b0;
         end
      end
   end

   `ASSERT_NEXT(a_strobe_one, clock, reset, rsp_valid, !rsp_valid,
                "result strobe lasted more than one cycle")
   `ASSERT_IMP(a_no_strobe_idle_start, clock, reset, rsp_valid, !busy,
               "result strobe while a request is in flight")
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy,
                "accepted request did not raise busy")
   `ASSERT_IMP(a_clear_needs_over, clock, reset,
               fin && inrange_ff && drop_en_ff && da.ev == EV_CLEAR,
               valid_rd && dover_rd, "drop clear without prior over state")
endmodule

// ===== verif/tb.sv =====
// Testbench for the port rate threshold alarm unit: directed and random counter samples
module tb;
   import prta_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // one result of the block
   typedef struct {
      logic [5:0]  port;
      logic [63:0] rx_rate;
      logic [63:0] tx_rate;
      logic [1:0]  drop_ev;
      logic [31:0] drop_val;
      logic [1:0]  band_ev;
      logic [31:0] band_val;
   } sample_result_type;

   // one counter sample request
   typedef struct {
      logic [5:0]  port;
      logic [31:0] secs;
      logic [63:0] rx;
      logic [63:0] tx;
      logic [63:0] pkts;
      logic [63:0] drops;
   } sample_req_type;

   // alarm decision: event, value, next over bit, next last-sent time
   typedef struct {
      logic [1:0]  ev;
      logic [31:0] val;
      logic        over;
      logic [31:0] last;
   } alarm_step_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [5:0]  req_port;
   logic [31:0] req_sample_secs;
   logic [63:0] req_rx_byte_count;
   logic [63:0] req_tx_byte_count;
   logic [63:0] req_rx_packet_count;
   logic [63:0] req_rx_drop_count;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;
   logic        rsp_valid;
   logic [5:0]  rsp_port_out;
   logic [63:0] rsp_rx_rate;
   logic [63:0] rsp_tx_rate;
   logic [1:0]  rsp_drop_event;
   logic [31:0] rsp_drop_value;
   logic [1:0]  rsp_band_event;
   logic [31:0] rsp_band_value;

   port_rate_threshold_alarm_unit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_port(req_port), .req_sample_secs(req_sample_secs),
      .req_rx_byte_count(req_rx_byte_count), .req_tx_byte_count(req_tx_byte_count),
      .req_rx_packet_count(req_rx_packet_count), .req_rx_drop_count(req_rx_drop_count),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_port_out(rsp_port_out),
      .rsp_rx_rate(rsp_rx_rate), .rsp_tx_rate(rsp_tx_rate),
      .rsp_drop_event(rsp_drop_event), .rsp_drop_value(rsp_drop_value),
      .rsp_band_event(rsp_band_event), .rsp_band_value(rsp_band_value)
   );

   // 12 ns clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // register mirror
   logic        m_drop_en;
   logic [7:0]  m_drop_thr;
   logic [31:0] m_drop_res;
   logic        m_band_en;
   logic [7:0]  m_band_thr;
   logic [31:0] m_band_res;
   logic [31:0] m_link_bps;

   // port table mirror
   logic        t_valid [64];
   logic [63:0] t_rx [64];
   logic [63:0] t_tx [64];
   logic [31:0] t_secs [64];
   logic        t_drop_over [64];
   logic [31:0] t_drop_last [64];
   logic        t_band_over [64];
   logic [31:0] t_band_last [64];

   sample_req_type    pending_reqs[$];
   sample_result_type expected_results[$];
   int             mismatches = 0;
   logic           took;
   logic           no_idle = 1'b0;
   int             gap_left = 0;

   // floor(100*n/d) saturated to 32 bits
   function automatic logic [31:0] percent_of(logic [63:0] n, logic [63:0] d);
      logic [127:0] q;
      q = ({64'd0, n} * 128'd100) / {64'd0, d};
      if (q > 128'hFFFF_FFFF) return 32'hFFFF_FFFF;
      return q[31:0];
   endfunction

   function automatic alarm_step_type alarm_next(logic [31:0] value, logic [7:0] thr,
                                                 logic [31:0] resend, logic [31:0] now,
                                                 logic over, logic [31:0] last);
      alarm_step_type a;
      logic fire;
      a.ev = EV_NONE;
      a.val = '0;
      a.over = 1'b0;
      a.last = '0;
      if (thr == 8'd0) begin
         // threshold switched off: clear a raised alarm, value 0
         if (over) a.ev = EV_CLEAR;
      end else if (value <= {24'd0, thr}) begin
         if (over) begin
            a.ev = EV_CLEAR;
            a.val = value;
         end
      end else begin
         fire = (resend == 32'd0) ? !over : ((now - last) > resend);
         a.over = 1'b1;
         a.last = last;
         if (fire) begin
            a.ev = EV_OVER;
            a.val = value;
            a.last = now;
         end
      end
      return a;
   endfunction

   // predicted result of one sample; updates the table mirror
   function automatic sample_result_type predict_sample(sample_req_type r);
      sample_result_type e;
      alarm_step_type a;
      logic [63:0] dt;
      logic [63:0] cap;
      int p;
      p = r.port;
      e.port = r.port;
      e.rx_rate = '0;
      e.tx_rate = '0;
      e.drop_ev = EV_NONE;
      e.drop_val = '0;
      e.band_ev = EV_NONE;
      e.band_val = '0;
      if (t_valid[p]) begin
         if (r.secs > t_secs[p]) begin
            dt = {32'd0, r.secs - t_secs[p]};
            if (r.rx > t_rx[p]) e.rx_rate = (r.rx - t_rx[p]) / dt;
            if (r.tx > t_tx[p]) e.tx_rate = (r.tx - t_tx[p]) / dt;
         end
      end else begin
         // first sample: history starts, alarms start not over
         t_valid[p] = 1'b1;
         t_drop_over[p] = 1'b0;
         t_drop_last[p] = '0;
         t_band_over[p] = 1'b0;
         t_band_last[p] = '0;
      end
      t_rx[p] = r.rx;
      t_tx[p] = r.tx;
      t_secs[p] = r.secs;
      if (m_drop_en) begin
         a = alarm_next((r.pkts != 0) ? percent_of(r.drops, r.pkts) : 32'd0,
                        m_drop_thr, m_drop_res, r.secs, t_drop_over[p], t_drop_last[p]);
         e.drop_ev = a.ev;
         e.drop_val = a.val;
         t_drop_over[p] = a.over;
         t_drop_last[p] = a.last;
      end
      if (m_band_en) begin
         cap = (m_link_bps != 0) ? {32'd0, m_link_bps} : 64'd1;
         a = alarm_next(percent_of(e.rx_rate, cap), m_band_thr, m_band_res, r.secs,
                        t_band_over[p], t_band_last[p]);
         e.band_ev = a.ev;
         e.band_val = a.val;
         t_band_over[p] = a.over;
         t_band_last[p] = a.last;
      end
      return e;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %0h want %0h (t=%0t)", what, got, want, $realtime);
      mismatches++;
   endtask

   // driver: requests change on the falling edge
   always @(negedge clock) begin
      sample_req_type r;
      logic next_start;
      if (reset) begin
         start <= 1'b0;
         took <= 1'b0;
      end else if (!start || took) begin
         next_start = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(1, 19) - 1;
         end else if (pending_reqs.size() > 0) begin
            r = pending_reqs.pop_front();
            req_port <= r.port;
            req_sample_secs <= r.secs;
            req_rx_byte_count <= r.rx;
            req_tx_byte_count <= r.tx;
            req_rx_packet_count <= r.pkts;
            req_rx_drop_count <= r.drops;
            next_start = 1'b1;
         end
         start <= next_start;
         took <= 1'b0;
      end
   end

   // monitor: check results, then predict newly accepted requests
   always @(posedge clock) begin
      sample_result_type e;
      sample_req_type r;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", {58'd0, rsp_port_out}, 64'd0);
            end else begin
               e = expected_results.pop_front();
               if (rsp_port_out !== e.port)
                  report_mismatch("port_out", 64'(rsp_port_out), 64'(e.port));
               if (rsp_rx_rate !== e.rx_rate) report_mismatch("rx_rate", rsp_rx_rate, e.rx_rate);
               if (rsp_tx_rate !== e.tx_rate) report_mismatch("tx_rate", rsp_tx_rate, e.tx_rate);
               if (rsp_drop_event !== e.drop_ev)
                  report_mismatch("drop_event", 64'(rsp_drop_event), 64'(e.drop_ev));
               if (rsp_drop_value !== e.drop_val)
                  report_mismatch("drop_value", 64'(rsp_drop_value), 64'(e.drop_val));
               if (rsp_band_event !== e.band_ev)
                  report_mismatch("band_event", 64'(rsp_band_event), 64'(e.band_ev));
               if (rsp_band_value !== e.band_val)
                  report_mismatch("band_value", 64'(rsp_band_value), 64'(e.band_val));
            end
         end
         if (start && !busy) begin
            r.port = req_port;
            r.secs = req_sample_secs;
            r.rx = req_rx_byte_count;
            r.tx = req_tx_byte_count;
            r.pkts = req_rx_packet_count;
            r.drops = req_rx_drop_count;
            expected_results.push_back(predict_sample(r));
            took <= 1'b1;
         end
      end
   end

   // generator state per port, for well-formed counter streams
   logic [31:0] g_secs [64];
   logic [63:0] g_rx [64];
   logic [63:0] g_tx [64];
   logic [63:0] g_pkts [64];
   logic [63:0] g_drops [64];

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic sample_req_type make_sample();
      sample_req_type r;
      logic [31:0] dt;
      logic [63:0] inc;
      int p;
      // a few ports mostly, so that history and alarm state build up
      p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 5);
      if ($urandom_range(0, 9) < 2) begin
         // noise: arbitrary counters
         g_secs[p] = $urandom;
         g_rx[p] = rand64() >> $urandom_range(0, 63);
         g_tx[p] = rand64() >> $urandom_range(0, 63);
         g_pkts[p] = rand64() >> $urandom_range(0, 63);
         g_drops[p] = rand64() >> $urandom_range(0, 63);
      end else begin
         dt = $urandom_range(0, 3);
         g_secs[p] = g_secs[p] + dt;
         inc = (dt == 0 ? 1 : dt) * $urandom_range(0, 4000);
         if ($urandom_range(0, 9) == 0) inc = rand64() >> $urandom_range(0, 63);
         if ($urandom_range(0, 19) == 0) inc = -$urandom_range(0, 100);
         g_rx[p] = g_rx[p] + inc;
         g_tx[p] = g_tx[p] + $urandom_range(0, 3000) * dt;
         inc = $urandom_range(0, 1000);
         g_pkts[p] = g_pkts[p] + inc;
         g_drops[p] = g_drops[p] + $urandom_range(0, inc);
      end
      r.port = 6'(p);
      r.secs = g_secs[p];
      r.rx = g_rx[p];
      r.tx = g_tx[p];
      r.pkts = g_pkts[p];
      r.drops = g_drops[p];
      return r;
   endfunction

   task automatic csr_set(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         CSR_DROP_EN:  m_drop_en = val[0];
         CSR_DROP_THR: m_drop_thr = val[7:0];
         CSR_DROP_RES: m_drop_res = val;
         CSR_BAND_EN:  m_band_en = val[0];
         CSR_BAND_THR: m_band_thr = val[7:0];
         CSR_BAND_RES: m_band_res = val;
         CSR_LINK_BPS: m_link_bps = val;
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic write_all(logic de, logic [7:0] dthr, logic [31:0] dres,
                            logic be, logic [7:0] bthr, logic [31:0] bres,
                            logic [31:0] link);
      csr_set(CSR_DROP_EN, {31'd0, de});
      csr_set(CSR_DROP_THR, {24'd0, dthr});
      csr_set(CSR_DROP_RES, dres);
      csr_set(CSR_BAND_EN, {31'd0, be});
      csr_set(CSR_BAND_THR, {24'd0, bthr});
      csr_set(CSR_BAND_RES, bres);
      csr_set(CSR_LINK_BPS, link);
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || start || busy || expected_results.size() > 0)
         @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic push_req(logic [5:0] p, logic [31:0] s, logic [63:0] rx,
                           logic [63:0] tx, logic [63:0] pk, logic [63:0] dr);
      sample_req_type r;
      r.port = p;
      r.secs = s;
      r.rx = rx;
      r.tx = tx;
      r.pkts = pk;
      r.drops = dr;
      pending_reqs.push_back(r);
   endtask

   // stimulus and end of run
   initial begin
      reset = 1'b1;
      start = 1'b0;
      took = 1'b0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_port = '0;
      req_sample_secs = '0;
      req_rx_byte_count = '0;
      req_tx_byte_count = '0;
      req_rx_packet_count = '0;
      req_rx_drop_count = '0;
      m_drop_en = 1'b0;
      m_drop_thr = '0;
      m_drop_res = '0;
      m_band_en = 1'b0;
      m_band_thr = '0;
      m_band_res = '0;
      m_link_bps = DefLinkBps;
      for (int i = 0; i < 64; i++) begin
         t_valid[i] = 1'b0;
         t_rx[i] = '0;
         t_tx[i] = '0;
         t_secs[i] = '0;
         t_drop_over[i] = 1'b0;
         t_drop_last[i] = '0;
         t_band_over[i] = 1'b0;
         t_band_last[i] = '0;
         g_secs[i] = $urandom_range(0, 1000);
         g_rx[i] = '0;
         g_tx[i] = '0;
         g_pkts[i] = '0;
         g_drops[i] = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // a few samples at reset defaults: alarms disabled
      push_req(6'd1, 32'd10, 64'd100, 64'd100, 64'd10, 64'd5);
      push_req(6'd1, 32'd12, 64'd900, 64'd50, 64'd20, 64'd15);
      wait_drained();

      // directed: low thresholds, tiny link so utilisation saturates
      write_all(1'b1, 8'd1, 32'd0, 1'b1, 8'd1, 32'd0, 32'd1);
      push_req(6'd0, 32'd0, 64'd0, 64'd0, 64'd0, 64'd0);            // first sample, zeros
      push_req(6'd63, '1, '1, '1, '1, '1);                          // all ones, first
      push_req(6'd0, 32'd0, 64'd500, 64'd500, 64'd0, 64'd9);        // time not advancing
      push_req(6'd0, 32'd5, 64'd100, 64'd1000, 64'd1, '1);          // rx shrinks, drop sat
      push_req(6'd0, 32'd6, '1, 64'd1000, 64'd10, 64'd1);           // huge rate, tx flat
      push_req(6'd0, 32'd7, '1, 64'd2000, 64'd100, 64'd1);          // falls back: clears
      push_req(6'd63, 32'd0, 64'd0, 64'd0, 64'd0, 64'd0);           // time went backward
      push_req(6'd2, 32'hFFFF_FFFE, 64'd0, 64'd0, 64'd4, 64'd4);
      push_req(6'd2, '1, '1, '1, 64'd4, 64'd4);                     // max delta in 1 s
      wait_drained();
      // threshold off while raised: clear with value 0
      write_all(1'b1, 8'd0, 32'd0, 1'b1, 8'd0, 32'd0, 32'd1);
      push_req(6'd2, '1, '1, '1, 64'd4, 64'd4);
      push_req(6'd0, 32'd9, '1, 64'd2000, 64'd1, 64'd1);
      wait_drained();
      // resend interval, then max resend
      write_all(1'b1, 8'd255, 32'd2, 1'b1, 8'd255, '1, 32'd0);
      for (int k = 0; k < 6; k++)
         push_req(6'd5, 32'd100 + k, 64'd1000 * k, 64'd7 * k, 64'd1, 64'd10);
      wait_drained();
      // disabled alarms keep state
      write_all(1'b0, 8'd1, 32'd1, 1'b0, 8'd1, 32'd1, '1);
      push_req(6'd5, 32'd200, 64'd0, 64'd0, 64'd1, 64'd10);
      wait_drained();

      // random phases over several register settings
      for (int ph = 0; ph < 10; ph++) begin
         case (ph % 5)
            0: write_all(1'b1, 8'd10, 32'd0, 1'b1, 8'd50, 32'd0, 32'd1000);
            1: write_all(1'b1, 8'd50, 32'd3, 1'b1, 8'd100, 32'd2, 32'd2000);
            2: write_all(1'b1, 8'd255, '1, 1'b1, 8'd255, '1, DefLinkBps);
            3: write_all(1'b1, 8'($urandom_range(0, 255)), 32'($urandom_range(0, 8)),
                         1'b1, 8'($urandom_range(0, 255)), 32'($urandom_range(0, 8)),
                         32'($urandom_range(1, 4000)));
            default: write_all(1'($urandom_range(0, 1)), 8'($urandom_range(0, 3)),
                               32'($urandom),
                               1'($urandom_range(0, 1)), 8'($urandom_range(0, 3)),
                               32'($urandom),
                               32'($urandom));
         endcase
         no_idle = (ph >= 8);
         for (int k = 0; k < 40; k++) pending_reqs.push_back(make_sample());
         wait_drained();
      end

      repeat (600) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
